>>> rtl/ffba_pkg.sv
package ffba_pkg;

  localparam int unsigned ArenaGranules = 16384;
  localparam int unsigned ChunkGranules = 1024;
  localparam int unsigned GranuleBytes  = 16;
  localparam int unsigned SplitMin      = 2;

  localparam int unsigned ReqW   = 18;
  localparam int unsigned OffW   = 18;
  localparam int unsigned SizeW  = 15;
  localparam int unsigned AddrW  = $clog2(ArenaGranules);
  localparam int unsigned GranSh = $clog2(GranuleBytes);

  // Largest block need (header included) and largest chunk-rounded growth.
  localparam int unsigned NeedMax  = ((2 ** ReqW) - 1 + 2 * GranuleBytes - 1) / GranuleBytes;
  localparam int unsigned ChunkMax = NeedMax + ChunkGranules - 1;
  localparam int unsigned NeedW    = $clog2(ChunkMax + 1);
  localparam int unsigned SumW     = $clog2(ArenaGranules + (2 ** SizeW) + ChunkMax + 1);

  typedef enum logic [0:0] {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    StatusOk  = 1'b0,
    StatusOom = 1'b1
  } status_e;

  typedef struct packed {
    op_e             operation;
    logic [ReqW-1:0] request_bytes;
    logic [OffW-1:0] payload_offset;
  } in_item_t;

  typedef struct packed {
    logic [OffW-1:0]  block_offset;
    logic [SizeW-1:0] granted_granules;
    status_e          status;
  } out_item_t;

  typedef struct packed {
    logic             re;
    logic [AddrW-1:0] raddr;
    logic             size_we;
    logic             used_we;
    logic [AddrW-1:0] waddr;
    logic [SizeW-1:0] wsize;
    logic             wused;
  } mem_req_t;

  typedef struct packed {
    logic [SizeW-1:0] size;
    logic             used;
  } mem_rsp_t;

endpackage

>>> rtl/ffba_ram.sv
module ffba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ffba_store.sv
module ffba_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ffba_pkg::mem_req_t req_i,
  output ffba_pkg::mem_rsp_t rsp_o
);

  logic [ffba_pkg::SizeW-1:0] size_rdata;
  logic                       used_rdata;
  logic                       size0_set_q, size0_set_d;
  logic                       used0_set_q, used0_set_d;
  logic                       rd0_q, rd0_d;

  ffba_ram #(
    .Width (ffba_pkg::SizeW),
    .Depth (ffba_pkg::ArenaGranules)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.size_we),
    .waddr_i (req_i.waddr),
    .wdata_i (req_i.wsize),
    .re_i    (req_i.re),
    .raddr_i (req_i.raddr),
    .rdata_o (size_rdata)
  );

  ffba_ram #(
    .Width (1),
    .Depth (ffba_pkg::ArenaGranules)
  ) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.used_we),
    .waddr_i (req_i.waddr),
    .wdata_i (req_i.wused),
    .re_i    (req_i.re),
    .raddr_i (req_i.raddr),
    .rdata_o (used_rdata)
  );

  // Granule zero is the initial end marker. Until it is written, reads of it
  // return the reset header (size zero, allocated) instead of the RAM word.
  always_comb begin
    size0_set_d = size0_set_q | (req_i.size_we && req_i.waddr == '0);
    used0_set_d = used0_set_q | (req_i.used_we && req_i.waddr == '0);
    rd0_d       = req_i.re ? (req_i.raddr == '0) : rd0_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size0_set_q <= 1'b0;
      used0_set_q <= 1'b0;
      rd0_q       <= 1'b0;
    end else begin
      size0_set_q <= size0_set_d;
      used0_set_q <= used0_set_d;
      rd0_q       <= rd0_d;
    end
  end

  assign rsp_o.size = (rd0_q && !size0_set_q) ? '0 : size_rdata;
  assign rsp_o.used = (rd0_q && !used0_set_q) ? 1'b1 : used_rdata;

endmodule

>>> rtl/ffba_obuf.sv
module ffba_obuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  ffba_pkg::out_item_t item_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                stall_i,
  output ffba_pkg::out_item_t item_o
);

  logic                valid_q, valid_d;
  ffba_pkg::out_item_t item_q, item_d;

  assign ready_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load_i && ready_o) begin
      valid_d = 1'b1;
      item_d  = item_i;
    end else if (valid_q && !stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/ffba_ctrl.sv
module ffba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ffba_pkg::in_item_t  in_item_i,
  output ffba_pkg::mem_req_t  mem_req_o,
  input  ffba_pkg::mem_rsp_t  mem_rsp_i,
  output logic                res_load_o,
  input  logic                res_ready_i,
  output ffba_pkg::out_item_t res_item_o
);

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StWalk   = 7'b0000010,
    StWrHdr  = 7'b0000100,
    StWrRest = 7'b0001000,
    StWrMark = 7'b0010000,
    StFree   = 7'b0100000,
    StDone   = 7'b1000000
  } state_e;

  localparam int unsigned SumW  = ffba_pkg::SumW;
  localparam int unsigned AddrW = ffba_pkg::AddrW;
  localparam int unsigned SizeW = ffba_pkg::SizeW;
  localparam int unsigned NeedW = ffba_pkg::NeedW;
  localparam int unsigned OffW  = ffba_pkg::OffW;
  localparam int unsigned GIdxW = OffW - ffba_pkg::GranSh;

  state_e                  state_q, state_d;
  logic [AddrW-1:0]        hdr_q, hdr_d;
  logic [AddrW-1:0]        end_q, end_d;
  logic [AddrW-1:0]        marker_q, marker_d;
  logic [NeedW-1:0]        need_q, need_d;
  logic [SizeW-1:0]        blk_q, blk_d;
  logic                    grow_q, grow_d;
  logic [OffW-1:0]         poff_q, poff_d;
  ffba_pkg::out_item_t     res_q, res_d;

  logic                    accept;
  logic [ffba_pkg::ReqW:0] req_sum;
  logic [NeedW-1:0]        need_new;
  logic [NeedW-1:0]        chunk;
  logic [SumW-1:0]         marker_sum;
  logic [SumW-1:0]         next_sum;
  logic                    fits;
  logic [SizeW-1:0]        extra;
  logic                    split;
  logic [SizeW-1:0]        final_size;
  logic [AddrW-1:0]        rest_addr;
  logic [AddrW:0]          hdr_plus1;
  logic [GIdxW-1:0]        free_gran;
  logic                    free_ok;

  assign accept     = in_valid_i && (state_q == StIdle);
  assign in_stall_o = (state_q != StIdle);

  // Block need in granules, header included: ceil((req + granule) / granule).
  assign req_sum  = {1'b0, in_item_i.request_bytes}
                  + (ffba_pkg::ReqW + 1)'(2 * ffba_pkg::GranuleBytes - 1);
  assign need_new = NeedW'(req_sum >> ffba_pkg::GranSh);

  assign chunk      = (need_q + NeedW'(ffba_pkg::ChunkGranules - 1))
                    & ~NeedW'(ffba_pkg::ChunkGranules - 1);
  assign marker_sum = SumW'(end_q) + SumW'(chunk);
  assign next_sum   = SumW'(hdr_q) + SumW'(mem_rsp_i.size);
  assign fits       = !mem_rsp_i.used && (SumW'(mem_rsp_i.size) >= SumW'(need_q));

  assign extra      = blk_q - SizeW'(need_q);
  assign split      = extra > SizeW'(ffba_pkg::SplitMin);
  assign final_size = split ? SizeW'(need_q) : blk_q;
  assign rest_addr  = AddrW'(SumW'(hdr_q) + SumW'(need_q));
  assign hdr_plus1  = {1'b0, hdr_q} + (AddrW + 1)'(1);

  assign free_gran = poff_q[OffW-1:ffba_pkg::GranSh];
  assign free_ok   = (poff_q[ffba_pkg::GranSh-1:0] == '0) && (free_gran != '0)
                  && (SumW'(free_gran) - SumW'(1) < SumW'(ffba_pkg::ArenaGranules));

  always_comb begin
    state_d    = state_q;
    hdr_d      = hdr_q;
    end_d      = end_q;
    marker_d   = marker_q;
    need_d     = need_q;
    blk_d      = blk_q;
    grow_d     = grow_q;
    poff_d     = poff_q;
    res_d      = res_q;
    mem_req_o  = '0;
    res_load_o = 1'b0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          need_d       = need_new;
          poff_d       = in_item_i.payload_offset;
          hdr_d        = '0;
          res_d        = '0;
          res_d.status = ffba_pkg::StatusOk;
          if (in_item_i.operation == ffba_pkg::OpFree) begin
            state_d = StFree;
          end else begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = '0;
            state_d         = StWalk;
          end
        end
      end
      StWalk: begin
        // The header read last cycle for hdr_q is on mem_rsp_i now.
        if (mem_rsp_i.size == '0) begin
          if (marker_sum >= SumW'(ffba_pkg::ArenaGranules)) begin
            res_d.status = ffba_pkg::StatusOom;
            state_d      = StDone;
          end else begin
            hdr_d    = end_q;
            blk_d    = SizeW'(chunk);
            marker_d = AddrW'(marker_sum);
            grow_d   = 1'b1;
            state_d  = StWrHdr;
          end
        end else if (fits) begin
          blk_d   = mem_rsp_i.size;
          grow_d  = 1'b0;
          state_d = StWrHdr;
        end else if (next_sum >= SumW'(ffba_pkg::ArenaGranules)) begin
          res_d.status = ffba_pkg::StatusOom;
          state_d      = StDone;
        end else begin
          hdr_d           = AddrW'(next_sum);
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = AddrW'(next_sum);
        end
      end
      StWrHdr: begin
        mem_req_o.size_we      = 1'b1;
        mem_req_o.used_we      = 1'b1;
        mem_req_o.waddr        = hdr_q;
        mem_req_o.wsize        = final_size;
        mem_req_o.wused        = 1'b1;
        res_d.block_offset     = OffW'({hdr_plus1, {ffba_pkg::GranSh{1'b0}}});
        res_d.granted_granules = final_size;
        res_d.status           = ffba_pkg::StatusOk;
        if (split) begin
          state_d = StWrRest;
        end else if (grow_q) begin
          state_d = StWrMark;
        end else begin
          state_d = StDone;
        end
      end
      StWrRest: begin
        mem_req_o.size_we = 1'b1;
        mem_req_o.used_we = 1'b1;
        mem_req_o.waddr   = rest_addr;
        mem_req_o.wsize   = extra;
        mem_req_o.wused   = 1'b0;
        state_d           = grow_q ? StWrMark : StDone;
      end
      StWrMark: begin
        mem_req_o.size_we = 1'b1;
        mem_req_o.used_we = 1'b1;
        mem_req_o.waddr   = marker_q;
        mem_req_o.wsize   = '0;
        mem_req_o.wused   = 1'b1;
        end_d             = marker_q;
        state_d           = StDone;
      end
      StFree: begin
        mem_req_o.used_we = free_ok;
        mem_req_o.waddr   = AddrW'(free_gran - GIdxW'(1));
        mem_req_o.wused   = 1'b0;
        state_d           = StDone;
      end
      StDone: begin
        res_load_o = 1'b1;
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      end_q   <= '0;
    end else begin
      state_q <= state_d;
      end_q   <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q    <= hdr_d;
    marker_q <= marker_d;
    need_q   <= need_d;
    blk_q    <= blk_d;
    grow_q   <= grow_d;
    poff_q   <= poff_d;
    res_q    <= res_d;
  end

  assign res_item_o = res_q;

`ifndef SYNTHESIS
  // The walk can only stop on a zero-size header at the tracked end marker.
  a_walk_end_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk && mem_rsp_i.size == '0) |-> (hdr_q == end_q))
    else $error("walk reached a zero-size header away from the end marker");

  a_grant_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrHdr) |-> (SumW'(need_q) <= SumW'(blk_q)))
    else $error("granted block is smaller than the request");

  a_marker_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrMark) |-> (grow_q && marker_q > hdr_q && hdr_q == end_q))
    else $error("end marker update without a matching growth");

  a_walk_starts_at_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.operation == ffba_pkg::OpAlloc)
      |=> (state_q == StWalk && hdr_q == '0))
    else $error("allocation did not start the walk at granule zero");
`endif

endmodule

>>> rtl/first_fit_block_allocator_top.sv
// Free: the used bit of the addressed header is cleared if the offset is valid, then the result is
// loaded into the output register. Allocate: the walk visits headers in order, one header read
// per cycle from the size and used RAMs, then does 0 to 3 header writes (0 on out of memory).
// One item is in flight at a time, so a new item is accepted only once the last result is loaded
// into the output register; the output register holds a result while the sink stalls.
// Reset is immediate: the end marker at granule zero comes from flops, no sweep.
module first_fit_block_allocator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ffba_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ffba_pkg::out_item_t out_data_o
);

  ffba_pkg::mem_req_t  mem_req;
  ffba_pkg::mem_rsp_t  mem_rsp;
  ffba_pkg::out_item_t res_item;
  logic                res_load;
  logic                res_ready;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_data_i),
    .mem_req_o   (mem_req),
    .mem_rsp_i   (mem_rsp),
    .res_load_o  (res_load),
    .res_ready_i (res_ready),
    .res_item_o  (res_item)
  );

  ffba_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rsp_o  (mem_rsp)
  );

  ffba_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_load),
    .item_i  (res_item),
    .ready_o (res_ready),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .item_o  (out_data_o)
  );

endmodule

>>> bench/first_fit_block_allocator_top_test.sv
`timescale 1ns / 1ps

module first_fit_block_allocator_top_test;

  localparam int unsigned CycleLimit = 100000000;
  localparam int unsigned DrainCycles = 20;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ffba_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ffba_pkg::out_item_t out_data;

  // Mirror of the header stores and the end marker, updated when a transaction is accepted.
  int unsigned blk_size [ffba_pkg::ArenaGranules];
  bit          blk_used [ffba_pkg::ArenaGranules];
  int unsigned end_gran;

  ffba_pkg::out_item_t       expected_results[$];
  logic [ffba_pkg::OffW-1:0] granted_offsets[$];
  ffba_pkg::out_item_t       next_result;
  int                        errors = 0;
  int unsigned               cycle_count = 0;
  int                        idle_pct = 0;
  int                        stall_pct = 0;

  first_fit_block_allocator_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic ffba_pkg::out_item_t arena_predict(input ffba_pkg::in_item_t it);
    ffba_pkg::out_item_t r;
    int unsigned         need;
    int unsigned         hdr;
    int unsigned         chunk;
    int unsigned         extra;
    int unsigned         g;
    bit                  found;
    r = '0;
    r.status = ffba_pkg::StatusOk;
    if (it.operation == ffba_pkg::OpFree) begin
      g = it.payload_offset / ffba_pkg::GranuleBytes;
      if ((it.payload_offset % ffba_pkg::GranuleBytes) == 0 && g >= 1
          && g - 1 < ffba_pkg::ArenaGranules) begin
        blk_used[g - 1] = 1'b0;
      end
      return r;
    end
    need = (it.request_bytes + 2 * ffba_pkg::GranuleBytes - 1) / ffba_pkg::GranuleBytes;
    hdr = 0;
    found = 1'b0;
    while (hdr < ffba_pkg::ArenaGranules && blk_size[hdr] != 0) begin
      if (!blk_used[hdr] && blk_size[hdr] >= need) begin
        found = 1'b1;
        break;
      end
      hdr += blk_size[hdr];
    end
    if (!found) begin
      chunk = ((need + ffba_pkg::ChunkGranules - 1) / ffba_pkg::ChunkGranules)
              * ffba_pkg::ChunkGranules;
      if (hdr >= ffba_pkg::ArenaGranules || hdr + chunk >= ffba_pkg::ArenaGranules) begin
        r.status = ffba_pkg::StatusOom;
        return r;
      end
      blk_size[hdr] = chunk;
      blk_used[hdr] = 1'b0;
      blk_size[hdr + chunk] = 0;
      blk_used[hdr + chunk] = 1'b1;
      end_gran = hdr + chunk;
    end
    extra = blk_size[hdr] - need;
    if (extra > ffba_pkg::SplitMin) begin
      blk_size[hdr] = need;
      if (hdr + need < ffba_pkg::ArenaGranules) begin
        blk_size[hdr + need] = extra;
        blk_used[hdr + need] = 1'b0;
      end
    end
    blk_used[hdr] = 1'b1;
    r.block_offset = ffba_pkg::OffW'((hdr + 1) * ffba_pkg::GranuleBytes);
    r.granted_granules = ffba_pkg::SizeW'(blk_size[hdr]);
    granted_offsets.push_back(r.block_offset);
    return r;
  endfunction

  function automatic ffba_pkg::in_item_t alloc_item(input logic [ffba_pkg::ReqW-1:0] bytes);
    ffba_pkg::in_item_t it;
    it.operation = ffba_pkg::OpAlloc;
    it.request_bytes = bytes;
    it.payload_offset = ffba_pkg::OffW'($urandom);
    return it;
  endfunction

  function automatic ffba_pkg::in_item_t free_item(input logic [ffba_pkg::OffW-1:0] offset);
    ffba_pkg::in_item_t it;
    it.operation = ffba_pkg::OpFree;
    it.request_bytes = ffba_pkg::ReqW'($urandom);
    it.payload_offset = offset;
    return it;
  endfunction

  task automatic send_item(input ffba_pkg::in_item_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(arena_predict(item));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Builds a short list by hand so that growth, splitting, the no-split boundary
  // (two spare granules) and an exact fit all occur in a known order.
  task automatic test_directed_alloc_split();
    send_item(free_item(ffba_pkg::OffW'(ffba_pkg::GranuleBytes)));
    send_item(alloc_item(0));
    send_item(alloc_item(1));
    send_item(alloc_item(32));
    send_item(alloc_item(32));
    send_item(alloc_item(64));
    send_item(free_item(ffba_pkg::OffW'(7 * ffba_pkg::GranuleBytes)));
    send_item(alloc_item(0));
    send_item(free_item(ffba_pkg::OffW'(10 * ffba_pkg::GranuleBytes)));
    send_item(alloc_item(16));
    send_item(alloc_item(32));
    send_item(alloc_item(17));
    send_item(alloc_item(ffba_pkg::ReqW'(ffba_pkg::ChunkGranules * ffba_pkg::GranuleBytes
                                         - ffba_pkg::GranuleBytes)));
    send_item(alloc_item(ffba_pkg::ReqW'(ffba_pkg::ChunkGranules * ffba_pkg::GranuleBytes
                                         - ffba_pkg::GranuleBytes + 1)));
  endtask

  task automatic test_free_corner_cases();
    send_item(free_item(17));
    send_item(free_item(0));
    send_item(free_item(8));
    send_item(free_item(ffba_pkg::OffW'((ffba_pkg::ArenaGranules - 1)
                                        * ffba_pkg::GranuleBytes)));
    send_item(free_item('1));
    // A granule in the middle of a free block is not a header.
    send_item(free_item(ffba_pkg::OffW'(501 * ffba_pkg::GranuleBytes)));
    send_item(alloc_item('1));
  endtask

  task automatic test_random_traffic(input int count, input int idle, input int stall);
    int                        n;
    int                        pick;
    int                        sel;
    logic [ffba_pkg::ReqW-1:0] bytes;
    logic [ffba_pkg::OffW-1:0] offset;
    idle_pct = idle;
    stall_pct = stall;
    for (n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (granted_offsets.size() != 0 && sel < (granted_offsets.size() > 48 ? 75 : 45)) begin
        sel = $urandom_range(99);
        if (sel < 85) begin
          pick = $urandom_range(granted_offsets.size() - 1);
          offset = granted_offsets[pick];
          granted_offsets.delete(pick);
        end else if (sel < 93) begin
          offset = ffba_pkg::OffW'($urandom);
        end else begin
          offset = ffba_pkg::OffW'($urandom_range(ffba_pkg::ArenaGranules - 1)
                                   * ffba_pkg::GranuleBytes);
        end
        send_item(free_item(offset));
      end else begin
        sel = $urandom_range(99);
        if (sel < 70) bytes = ffba_pkg::ReqW'($urandom_range(255));
        else if (sel < 90) bytes = ffba_pkg::ReqW'($urandom_range(4095));
        else if (sel < 97) bytes = ffba_pkg::ReqW'($urandom_range(65535));
        else bytes = ffba_pkg::ReqW'($urandom);
        send_item(alloc_item(bytes));
      end
    end
  endtask

  task automatic test_arena_full();
    int unsigned chunks;
    idle_pct = 0;
    stall_pct = 20;
    chunks = (ffba_pkg::ArenaGranules - 1 - end_gran) / ffba_pkg::ChunkGranules;
    // Grow by the most whole chunks that still leave room for the end marker.
    if (chunks > 0) begin
      send_item(alloc_item(ffba_pkg::ReqW'(chunks * ffba_pkg::ChunkGranules
                                           * ffba_pkg::GranuleBytes
                                           - ffba_pkg::GranuleBytes)));
    end
    send_item(alloc_item(ffba_pkg::ReqW'(ffba_pkg::ChunkGranules * ffba_pkg::GranuleBytes
                                         - ffba_pkg::GranuleBytes)));
    send_item(alloc_item('1));
    send_item(alloc_item(0));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected: block_offset %0d",
               out_data.block_offset);
        errors++;
      end else begin
        next_result = expected_results.pop_front();
        if (out_data.block_offset !== next_result.block_offset) begin
          $error("block_offset: expected %0d, actual %0d",
                 next_result.block_offset, out_data.block_offset);
          errors++;
        end
        if (out_data.granted_granules !== next_result.granted_granules) begin
          $error("granted_granules: expected %0d, actual %0d",
                 next_result.granted_granules, out_data.granted_granules);
          errors++;
        end
        if (out_data.status !== next_result.status) begin
          $error("status: expected %0d, actual %0d", next_result.status, out_data.status);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int g = 0; g < ffba_pkg::ArenaGranules; g++) begin
      blk_size[g] = 0;
      blk_used[g] = 1'b0;
    end
    blk_used[0] = 1'b1;
    end_gran = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_alloc_split();
    test_free_corner_cases();
    wait_drained();
    test_random_traffic(300, 0, 0);
    test_random_traffic(300, 64, 0);
    wait_drained();
    test_random_traffic(300, 0, 64);
    test_random_traffic(300, 15, 15);
    test_arena_full();
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ffba_pkg.sv
rtl/ffba_ram.sv
rtl/ffba_store.sv
rtl/ffba_obuf.sv
rtl/ffba_ctrl.sv
rtl/first_fit_block_allocator_top.sv
bench/first_fit_block_allocator_top_test.sv
